>>> rtl/core/rsrb_pkg.sv
// ----------------------------------------------------------------------------
// RTP reorder buffer package
// Shared types, sizes and codes of the RTP sequence reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsrb_pkg;

  // Buffer geometry. SLOTS is a power of two so slot indexes wrap by width.
  localparam int SLOTS = 32;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;

  // Field widths.
  localparam int SEQ_W = 16;
  localparam int LEN_W = 14;
  localparam int REF_W = 12;

  // Reorder window and the depth behind the head that still counts as old.
  localparam int WINDOW     = 32;
  localparam int OLD_FACTOR = 3;
  localparam int OLD_SPAN   = OLD_FACTOR * WINDOW;

  localparam logic signed [SEQ_W:0] OFF_WINDOW = (SEQ_W + 1)'(WINDOW);
  localparam logic signed [SEQ_W:0] OFF_OLD    = (SEQ_W + 1)'(-OLD_SPAN);

  // Start value of the minimum search: above every sequence number.
  localparam logic [SEQ_W:0] MIN_INIT = {1'b1, {SEQ_W{1'b0}}};

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    EV_DIRECT   = 4'd0,
    EV_STORED   = 4'd1,
    EV_NULL     = 4'd2,
    EV_STRAY    = 4'd3,
    EV_OLD      = 4'd4,
    EV_OVERRUN  = 4'd5,
    EV_UNDERRUN = 4'd6,
    EV_DRAINED  = 4'd7,
    EV_EMPTY    = 4'd8
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR_EVAL,
    ST_ARR_SCAN,
    ST_DRN_SCAN,
    ST_DRN_SEL,
    ST_DRN_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e              operation;
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] payload_length;
    logic [REF_W-1:0] payload_ref;
  } in_t;

  typedef struct packed {
    event_e           event_res;
    logic [REF_W-1:0] payload_ref_out;
    logic [LEN_W-1:0] delivered_length;
    logic [SEQ_W-1:0] delivered_seq;
    logic [SEQ_W-1:0] lost_count;
    logic             head_ready;
  } out_t;

endpackage

`default_nettype wire

>>> rtl/core/rtp_sequence_reorder_buffer.sv
// ----------------------------------------------------------------------------
// RTP sequence reorder buffer
// Circular buffer of slots that puts RTP packets back in sequence order.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (in_valid_i, in_stall_o, in_i) is either a
// packet arrival or a drain. Every request yields exactly one result on the
// output channel (out_valid_o, out_stall_i, out_o).
// The block works on one request at a time and holds in_stall_o high while
// busy. One set of slot memories with a single read port is walked by a
// small sequencer, one slot per cycle. The steps per request are:
//   arrival not behind the head, or null: evaluate, then hand over the result
//   arrival behind the head: evaluate, stray search over all slots, hand over
//   drain: minimum search over all slots, select, evaluate, hand over
// The next request is taken in the cycle after the result is handed over.
// The finished result sits in an output register, so a new request is taken
// while the receiver stalls; the next result then waits until the register
// is free. Reset empties every slot, puts the head at slot zero and arms the
// first-packet rule; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_sequence_reorder_buffer (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rsrb_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rsrb_pkg::out_t      out_o
);

  // Sequencer state.
  rsrb_pkg::state_e state_q, state_d;

  // Request and result registers.
  rsrb_pkg::in_t  item_q, item_d;
  rsrb_pkg::out_t res_q, res_d;
  rsrb_pkg::out_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  // Buffer control state.
  logic [rsrb_pkg::IDX_W-1:0] head_q, head_d;
  logic [rsrb_pkg::SEQ_W-1:0] exp_q, exp_d;
  logic                       first_q, first_d;
  logic [rsrb_pkg::SLOTS-1:0] occ_q, occ_d;
  logic [rsrb_pkg::SLOTS-1:0] sv_q, sv_d;

  // Search state.
  logic [rsrb_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       found_q, found_d;
  logic                       old_q, old_d;
  logic [rsrb_pkg::SEQ_W:0]   min_seq_q, min_seq_d;
  logic [rsrb_pkg::IDX_W-1:0] min_idx_q, min_idx_d;

  // Slot memories and their read and write ports.
  logic [rsrb_pkg::SEQ_W-1:0] seq_mem [rsrb_pkg::SLOTS];
  logic [rsrb_pkg::LEN_W-1:0] len_mem [rsrb_pkg::SLOTS];
  logic [rsrb_pkg::REF_W-1:0] ref_mem [rsrb_pkg::SLOTS];
  logic [rsrb_pkg::IDX_W-1:0] rd_addr;
  logic [rsrb_pkg::IDX_W-1:0] wr_addr;
  logic                       seq_we;
  logic                       pay_we;
  logic [rsrb_pkg::SEQ_W-1:0] seq_wd;
  logic [rsrb_pkg::SEQ_W-1:0] rd_seq_raw_q;
  logic [rsrb_pkg::LEN_W-1:0] rd_len_q;
  logic [rsrb_pkg::REF_W-1:0] rd_ref_q;
  logic                       rd_sv_q;
  logic                       rd_occ_q;

  // Decoded values.
  logic [rsrb_pkg::SEQ_W-1:0] rd_seq;
  logic signed [rsrb_pkg::SEQ_W:0] off;
  logic                       len_zero;
  logic                       off_zero;
  logic                       off_over;
  logic                       off_neg;
  logic                       cnt_last;
  logic [rsrb_pkg::IDX_W-1:0] adv_idx;
  logic [rsrb_pkg::IDX_W-1:0] store_idx;
  logic [rsrb_pkg::IDX_W-1:0] prev_idx;
  logic [rsrb_pkg::SEQ_W-1:0] seq_inc;
  logic [rsrb_pkg::SEQ_W-1:0] hseq_inc;
  logic                       scan_hit;
  logic                       scan_better;
  logic                       out_free;
  logic                       deliver;

  // Handshake outputs.
  assign in_stall_o  = (state_q != rsrb_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // A slot whose sequence was never written reads as zero.
  assign rd_seq = rd_sv_q ? rd_seq_raw_q : '0;

  // Offset of the arrival from the head sequence, a plain signed difference.
  assign off = $signed({1'b0, item_q.seq_number}) - $signed({1'b0, rd_seq});

  assign len_zero  = (item_q.payload_length == '0);
  assign off_zero  = (off == '0);
  assign off_over  = (off > rsrb_pkg::OFF_WINDOW);
  assign off_neg   = off[rsrb_pkg::SEQ_W];
  assign cnt_last  = (cnt_q == rsrb_pkg::CNT_W'(rsrb_pkg::SLOTS));
  assign adv_idx   = head_q + rsrb_pkg::IDX_W'(1);
  assign store_idx = head_q + off[rsrb_pkg::IDX_W-1:0];
  assign prev_idx  = rsrb_pkg::IDX_W'(cnt_q - rsrb_pkg::CNT_W'(1));
  assign seq_inc   = item_q.seq_number + rsrb_pkg::SEQ_W'(1);
  assign hseq_inc  = rd_seq + rsrb_pkg::SEQ_W'(1);

  // Search compares use the slot read in the previous cycle.
  assign scan_hit    = (cnt_q != '0) && (rd_seq == item_q.seq_number);
  assign scan_better = (cnt_q != '0) && rd_occ_q && ({1'b0, rd_seq} < min_seq_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rsrb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_i.operation == rsrb_pkg::OP_DRAIN) ? rsrb_pkg::ST_DRN_SCAN
                                                           : rsrb_pkg::ST_ARR_EVAL;
        end
      end
      rsrb_pkg::ST_ARR_EVAL: begin
        if (!len_zero && !off_zero && !first_q && !off_over && off_neg) begin
          state_d = rsrb_pkg::ST_ARR_SCAN;
        end else begin
          state_d = rsrb_pkg::ST_DONE;
        end
      end
      rsrb_pkg::ST_ARR_SCAN: begin
        if (cnt_last) begin
          state_d = rsrb_pkg::ST_DONE;
        end
      end
      rsrb_pkg::ST_DRN_SCAN: begin
        if (cnt_last) begin
          state_d = rsrb_pkg::ST_DRN_SEL;
        end
      end
      rsrb_pkg::ST_DRN_SEL:  state_d = rsrb_pkg::ST_DRN_EVAL;
      rsrb_pkg::ST_DRN_EVAL: state_d = rsrb_pkg::ST_DONE;
      rsrb_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rsrb_pkg::ST_IDLE;
        end
      end
      default: state_d = rsrb_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory port control for each sequencer state.
  always_comb begin
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    head_d      = head_q;
    exp_d       = exp_q;
    first_d     = first_q;
    occ_d       = occ_q;
    sv_d        = sv_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    old_d       = old_q;
    min_seq_d   = min_seq_q;
    min_idx_d   = min_idx_q;
    rd_addr     = head_q;
    wr_addr     = head_q;
    seq_we      = 1'b0;
    pay_we      = 1'b0;
    seq_wd      = seq_inc;
    deliver     = 1'b0;

    case (state_q)
      rsrb_pkg::ST_IDLE: begin
        // The head slot is read at the edge that takes the request.
        if (in_valid_i) begin
          item_d    = in_i;
          cnt_d     = '0;
          found_d   = 1'b0;
          min_seq_d = rsrb_pkg::MIN_INIT;
          min_idx_d = '0;
        end
      end

      rsrb_pkg::ST_ARR_EVAL: begin
        res_d = '0;
        old_d = (off > rsrb_pkg::OFF_OLD);
        if (len_zero) begin
          res_d.event_res = rsrb_pkg::EV_NULL;
        end else if (off_zero || first_q) begin
          // In sequence, or the first packet: step the head and expect the next sequence there.
          first_d         = 1'b0;
          head_d          = adv_idx;
          wr_addr         = adv_idx;
          seq_we          = 1'b1;
          sv_d[adv_idx]   = 1'b1;
          exp_d           = seq_inc;
          res_d.event_res = rsrb_pkg::EV_DIRECT;
          deliver         = 1'b1;
        end else if (off_over) begin
          // Too far ahead: empty the buffer and restart after this packet.
          occ_d           = '0;
          head_d          = '0;
          wr_addr         = '0;
          seq_we          = 1'b1;
          sv_d[0]         = 1'b1;
          exp_d           = seq_inc;
          res_d.event_res = rsrb_pkg::EV_OVERRUN;
          deliver         = 1'b1;
        end else if (!off_neg) begin
          // Ahead inside the window: park the packet in its slot.
          wr_addr         = store_idx;
          seq_we          = 1'b1;
          pay_we          = 1'b1;
          seq_wd          = item_q.seq_number;
          sv_d[store_idx] = 1'b1;
          occ_d[store_idx] = 1'b1;
          res_d.event_res = rsrb_pkg::EV_STORED;
        end
      end

      rsrb_pkg::ST_ARR_SCAN: begin
        // Look for the sequence in every slot, occupied or not.
        rd_addr = cnt_q[rsrb_pkg::IDX_W-1:0];
        if (!cnt_last) begin
          cnt_d = cnt_q + rsrb_pkg::CNT_W'(1);
        end
        if (scan_hit) begin
          found_d = 1'b1;
        end
        if (cnt_last) begin
          res_d = '0;
          if (found_q || scan_hit) begin
            res_d.event_res = rsrb_pkg::EV_STRAY;
          end else if (old_q) begin
            res_d.event_res = rsrb_pkg::EV_OLD;
          end else begin
            occ_d           = '0;
            head_d          = '0;
            wr_addr         = '0;
            seq_we          = 1'b1;
            sv_d[0]         = 1'b1;
            exp_d           = seq_inc;
            res_d.event_res = rsrb_pkg::EV_UNDERRUN;
            deliver         = 1'b1;
          end
        end
      end

      rsrb_pkg::ST_DRN_SCAN: begin
        // Track the occupied slot with the lowest sequence, first on a tie.
        rd_addr = cnt_q[rsrb_pkg::IDX_W-1:0];
        if (!cnt_last) begin
          cnt_d = cnt_q + rsrb_pkg::CNT_W'(1);
        end
        if (scan_better) begin
          min_seq_d = {1'b0, rd_seq};
          min_idx_d = prev_idx;
        end
      end

      rsrb_pkg::ST_DRN_SEL: begin
        // Move the head to the winner, if any slot was occupied.
        if (!min_seq_q[rsrb_pkg::SEQ_W]) begin
          head_d  = min_idx_q;
          rd_addr = min_idx_q;
        end
      end

      rsrb_pkg::ST_DRN_EVAL: begin
        res_d = '0;
        if (rd_occ_q) begin
          res_d.event_res        = rsrb_pkg::EV_DRAINED;
          res_d.payload_ref_out  = rd_ref_q;
          res_d.delivered_length = rd_len_q;
          res_d.delivered_seq    = rd_seq;
          if (rd_seq > exp_q) begin
            res_d.lost_count = rd_seq - exp_q;
          end
        end else begin
          res_d.event_res = rsrb_pkg::EV_EMPTY;
        end
        occ_d[head_q] = 1'b0;
        head_d        = adv_idx;
        wr_addr       = adv_idx;
        seq_we        = 1'b1;
        seq_wd        = hseq_inc;
        sv_d[adv_idx] = 1'b1;
        exp_d         = hseq_inc;
      end

      rsrb_pkg::ST_DONE: begin
        // Hand the result over once the output register is free.
        if (out_free) begin
          out_d            = res_q;
          out_d.head_ready = occ_q[head_q];
          out_valid_d      = 1'b1;
        end
      end

      default: ;
    endcase

    // Delivered arrivals pass their own fields through.
    if (deliver) begin
      res_d.payload_ref_out  = item_q.payload_ref;
      res_d.delivered_length = item_q.payload_length;
      res_d.delivered_seq    = item_q.seq_number;
    end
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (seq_we) begin
      seq_mem[wr_addr] <= seq_wd;
    end
    if (pay_we) begin
      len_mem[wr_addr] <= item_q.payload_length;
      ref_mem[wr_addr] <= item_q.payload_ref;
    end
    rd_seq_raw_q <= seq_mem[rd_addr];
    rd_len_q     <= len_mem[rd_addr];
    rd_ref_q     <= ref_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsrb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      exp_q       <= '0;
      first_q     <= 1'b1;
      occ_q       <= '0;
      sv_q        <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      old_q       <= 1'b0;
      min_seq_q   <= rsrb_pkg::MIN_INIT;
      min_idx_q   <= '0;
      rd_sv_q     <= 1'b0;
      rd_occ_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      exp_q       <= exp_d;
      first_q     <= first_d;
      occ_q       <= occ_d;
      sv_q        <= sv_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      old_q       <= old_d;
      min_seq_q   <= min_seq_d;
      min_idx_q   <= min_idx_d;
      rd_sv_q     <= sv_q[rd_addr];
      rd_occ_q    <= occ_q[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

`ifndef SYNTH
  // An occupied slot always has a written sequence number.
  a_occ_has_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q & ~sv_q) == '0)
    else $error("occupied slot without a written sequence");

  // A stored packet marks its slot occupied.
  a_store_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_we |=> occ_q[$past(wr_addr)])
    else $error("stored packet left its slot empty");

  // The search counter never runs past SLOTS.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rsrb_pkg::CNT_W'(rsrb_pkg::SLOTS))
    else $error("search counter out of range");

  // A taken request makes the sequencer busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != rsrb_pkg::ST_IDLE))
    else $error("request taken without leaving idle");
`endif

endmodule

`default_nettype wire
